// ===== rtl/lpra_pkg.sv =====
`timescale 1ns / 1ps

package lpra_pkg;

  localparam int ROUTE_ENTRIES_DEF = 1024;
  localparam int ARP_ENTRIES_DEF   = 16;

  // wide enough to hold any table size or count for a limit compare
  localparam int CNT_W = 17;

  localparam int SLOT_W      = 10;
  localparam int ROUTE_CFG_W = 11;
  localparam int ARP_CFG_W   = 5;

  localparam logic [1:0] FUNC_ROUTE_WR = 2'd0;
  localparam logic [1:0] FUNC_ARP_WR   = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP   = 2'd2;

  localparam logic REG_ROUTE_COUNT = 1'b0;
  localparam logic REG_ARP_COUNT   = 1'b1;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [7:0]  port;
  } route_entry_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } arp_entry_t;

  typedef struct packed {
    logic        route_found;
    logic        arp_found;
    logic [7:0]  out_port;
    logic [31:0] out_gateway;
    logic [47:0] out_mac;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_ASCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/lpra_ram.sv =====
`timescale 1ns / 1ps

module lpra_ram
  import lpra_pkg::*;
#(
  parameter int DEPTH = ROUTE_ENTRIES_DEF,
  parameter int WIDTH = $bits(route_entry_t),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lpra_seq.sv =====
`timescale 1ns / 1ps

module lpra_seq
  import lpra_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int ARP_ENTRIES   = ARP_ENTRIES_DEF,
  localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
  localparam int RCNT_W = $clog2(ROUTE_ENTRIES + 1),
  localparam int AIDX_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1,
  localparam int ACNT_W = $clog2(ARP_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [31:0]       dst,
  input  logic [RCNT_W-1:0] n_route,
  input  logic [ACNT_W-1:0] n_arp,
  output logic              busy,
  output logic              route_rd_en,
  output logic [RIDX_W-1:0] route_rd_addr,
  input  route_entry_t      route_rd_data,
  output logic              arp_rd_en,
  output logic [AIDX_W-1:0] arp_rd_addr,
  input  arp_entry_t        arp_rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  state_t state, state_next;

  logic [31:0]       dst_q;
  logic [RCNT_W-1:0] r_issue;
  logic              r_pend;
  logic [ACNT_W-1:0] a_issue;
  logic              a_pend;
  logic              have_route;
  logic              have_arp;
  logic [31:0]       best_mask;
  logic [31:0]       best_hop;
  logic [7:0]        best_port;
  logic [47:0]       best_mac;

  logic        r_more;
  logic        a_more;
  logic        res_load;
  logic [31:0] eq_a;
  logic [31:0] eq_b;
  logic        eq_hit;
  logic        mask_better;

  assign r_more = (r_issue < n_route);
  assign a_more = (a_issue < n_arp) && !have_arp;

  // shared equality compare: route match during the route pass, next hop
  // against ARP IP during the ARP pass
  assign eq_a   = (state == ST_ASCAN) ? arp_rd_data.ip : (dst_q & route_rd_data.mask);
  assign eq_b   = (state == ST_ASCAN) ? best_hop : route_rd_data.prefix;
  assign eq_hit = (eq_a == eq_b);

  // strict greater keeps the earliest entry on equal masks
  assign mask_better = !have_route || (route_rd_data.mask > best_mask);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RSCAN;
        end
      end
      ST_RSCAN: begin
        if (!r_more && !r_pend) begin
          state_next = have_route ? ST_ASCAN : ST_DONE;
        end
      end
      ST_ASCAN: begin
        if (have_arp || (!a_more && !a_pend)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    route_rd_en   = 1'b0;
    arp_rd_en     = 1'b0;
    res_load      = 1'b0;
    route_rd_addr = r_issue[RIDX_W-1:0];
    arp_rd_addr   = a_issue[AIDX_W-1:0];
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_RSCAN: begin
        route_rd_en = r_more;
      end
      ST_ASCAN: begin
        arp_rd_en = a_more;
      end
      ST_DONE: begin
        res_load = !res_valid || res_ready;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      r_pend    <= 1'b0;
      a_pend    <= 1'b0;
      have_route <= 1'b0;
      have_arp  <= 1'b0;
      r_issue   <= '0;
      a_issue   <= '0;
    end else begin
      state  <= state_next;
      r_pend <= route_rd_en;
      a_pend <= arp_rd_en;

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (start) begin
        r_issue    <= '0;
        a_issue    <= '0;
        have_route <= 1'b0;
        have_arp   <= 1'b0;
      end else begin
        if (route_rd_en) begin
          r_issue <= r_issue + 1'b1;
        end
        if (arp_rd_en) begin
          a_issue <= a_issue + 1'b1;
        end
        if (state == ST_RSCAN && r_pend && eq_hit && mask_better) begin
          have_route <= 1'b1;
        end
        if (state == ST_ASCAN && a_pend && !have_arp && eq_hit) begin
          have_arp <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dst_q     <= dst;
      best_mask <= '0;
      best_hop  <= '0;
      best_port <= '0;
      best_mac  <= '0;
    end else begin
      if (state == ST_RSCAN && r_pend && eq_hit && mask_better) begin
        best_mask <= route_rd_data.mask;
        best_hop  <= route_rd_data.hop;
        best_port <= route_rd_data.port;
      end
      if (state == ST_ASCAN && a_pend && !have_arp && eq_hit) begin
        best_mac <= arp_rd_data.mac;
      end
    end
    if (res_load) begin
      res.route_found <= have_route;
      res.arp_found   <= have_arp;
      res.out_port    <= best_port;
      res.out_gateway <= best_hop;
      res.out_mac     <= best_mac;
    end
  end

`ifndef ASSERT_OFF
  a_arp_needs_route: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.route_found || !res.arp_found))
    else $error("ARP hit reported without a route");

  a_no_route_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.route_found) |->
      (res.out_port == 8'd0 && res.out_gateway == 32'd0 && res.out_mac == 48'd0))
    else $error("route fields not zero on a miss");

  a_start_scans: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_RSCAN))
    else $error("lookup did not enter the route scan");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_valid && !res_ready) |=> (state == ST_DONE))
    else $error("pending result would be overwritten");

  a_arp_flag: assert property (@(posedge clk) disable iff (rst)
    have_arp |-> have_route)
    else $error("ARP hit set with no route");
`endif

endmodule

// ===== rtl/longest_prefix_route_and_arp_lookup_top.sv =====
`timescale 1ns / 1ps

// Route and ARP lookup by longest prefix match over a linear table. Items on
// the slave stream carry a function code in s_tuser: route write and ARP write
// store one entry (a slot beyond the table size is dropped) and return
// nothing; a lookup returns one result. After a write the next item can
// follow at once. A lookup reads the route table through its single RAM read
// port one entry per cycle over the route_count entries in use, keeping the
// greatest matching mask (earliest entry on a tie), then reads the ARP table
// one entry per cycle until the next hop is found or arp_count entries are
// done; the ARP pass is skipped when no route matches. s_tready is low while a
// lookup runs and rises with m_tvalid; a finished result waits in an output
// register while the next item is taken, and a lookup that finishes while
// that register is still full holds until it drains. Counts above the table
// size act as the table size. Tables power up undefined: only written entries
// may be counted in use.
module longest_prefix_route_and_arp_lookup_top
  import lpra_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int ARP_ENTRIES   = ARP_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // slot, addr, mask, gateway, port, mac, zero pad
  input  logic [167:0]           s_tdata,
  // func
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // route_found, arp_found, out_port, out_gateway, out_mac, zero pad
  output logic [95:0]            m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [ROUTE_CFG_W-1:0] cfg_data
);

  localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int RCNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam int AIDX_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
  localparam int ACNT_W = $clog2(ARP_ENTRIES + 1);

  logic [ROUTE_CFG_W-1:0] route_count;
  logic [ARP_CFG_W-1:0]   arp_count;

  logic [SLOT_W-1:0] in_slot;
  logic [31:0]       in_addr;
  logic [31:0]       in_mask;
  logic [31:0]       in_hop;
  logic [7:0]        in_port;
  logic [47:0]       in_mac;

  logic         accept;
  logic         busy;
  logic [CNT_W-1:0] slot_w;
  logic [CNT_W-1:0] rc_w;
  logic [CNT_W-1:0] ac_w;
  logic [CNT_W-1:0] rc_lim;
  logic [CNT_W-1:0] ac_lim;

  logic              route_wr_en;
  logic              arp_wr_en;
  route_entry_t      route_wr_data;
  arp_entry_t        arp_wr_data;
  logic              route_rd_en;
  logic [RIDX_W-1:0] route_rd_addr;
  route_entry_t      route_rd_data;
  logic              arp_rd_en;
  logic [AIDX_W-1:0] arp_rd_addr;
  arp_entry_t        arp_rd_data;
  result_t           res;

  assign in_slot = s_tdata[9:0];
  assign in_addr = s_tdata[41:10];
  assign in_mask = s_tdata[73:42];
  assign in_hop  = s_tdata[105:74];
  assign in_port = s_tdata[113:106];
  assign in_mac  = s_tdata[161:114];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      arp_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROUTE_COUNT: route_count <= cfg_data;
        REG_ARP_COUNT:   arp_count   <= cfg_data[ARP_CFG_W-1:0];
        default:         route_count <= route_count;
      endcase
    end
  end

  // saturate the counts at the table sizes
  assign rc_w   = CNT_W'(route_count);
  assign ac_w   = CNT_W'(arp_count);
  assign rc_lim = (rc_w > CNT_W'(ROUTE_ENTRIES)) ? CNT_W'(ROUTE_ENTRIES) : rc_w;
  assign ac_lim = (ac_w > CNT_W'(ARP_ENTRIES)) ? CNT_W'(ARP_ENTRIES) : ac_w;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign slot_w   = CNT_W'(in_slot);

  assign route_wr_en = accept && (s_tuser == FUNC_ROUTE_WR) &&
                       (slot_w < CNT_W'(ROUTE_ENTRIES));
  assign arp_wr_en   = accept && (s_tuser == FUNC_ARP_WR) &&
                       (slot_w < CNT_W'(ARP_ENTRIES));

  assign route_wr_data.prefix = in_addr;
  assign route_wr_data.mask   = in_mask;
  assign route_wr_data.hop    = in_hop;
  assign route_wr_data.port   = in_port;
  assign arp_wr_data.ip       = in_addr;
  assign arp_wr_data.mac      = in_mac;

  lpra_ram #(
    .DEPTH (ROUTE_ENTRIES),
    .WIDTH ($bits(route_entry_t))
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (route_wr_en),
    .wr_addr (slot_w[RIDX_W-1:0]),
    .wr_data (route_wr_data),
    .rd_en   (route_rd_en),
    .rd_addr (route_rd_addr),
    .rd_data (route_rd_data)
  );

  lpra_ram #(
    .DEPTH (ARP_ENTRIES),
    .WIDTH ($bits(arp_entry_t))
  ) u_arp_ram (
    .clk     (clk),
    .wr_en   (arp_wr_en),
    .wr_addr (slot_w[AIDX_W-1:0]),
    .wr_data (arp_wr_data),
    .rd_en   (arp_rd_en),
    .rd_addr (arp_rd_addr),
    .rd_data (arp_rd_data)
  );

  lpra_seq #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .ARP_ENTRIES   (ARP_ENTRIES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (accept && (s_tuser == FUNC_LOOKUP)),
    .dst           (in_addr),
    .n_route       (rc_lim[RCNT_W-1:0]),
    .n_arp         (ac_lim[ACNT_W-1:0]),
    .busy          (busy),
    .route_rd_en   (route_rd_en),
    .route_rd_addr (route_rd_addr),
    .route_rd_data (route_rd_data),
    .arp_rd_en     (arp_rd_en),
    .arp_rd_addr   (arp_rd_addr),
    .arp_rd_data   (arp_rd_data),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res           (res)
  );

  assign m_tdata = {6'd0, res.out_mac, res.out_gateway, res.out_port,
                    res.arp_found, res.route_found};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lpra_pkg::*;

  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RX_HOLD_CYCLES = 400;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // one row of stimulus: an input transaction or a register write
  typedef struct packed {
    logic                   is_reg;
    logic                   reg_idx;
    logic [ROUTE_CFG_W-1:0] reg_val;
    logic [1:0]             func;
    logic [9:0]             slot;
    logic [31:0]            addr;
    logic [31:0]            mask;
    logic [31:0]            hop;
    logic [7:0]             port;
    logic [47:0]            mac;
    logic                   typed;
    result_t                want;
  } req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [167:0]           s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [95:0]            m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [ROUTE_CFG_W-1:0] cfg_data = '0;

  // shadow of the tables and registers
  logic [31:0]          rt_prefix [ROUTE_ENTRIES_DEF];
  logic [31:0]          rt_mask   [ROUTE_ENTRIES_DEF];
  logic [31:0]          rt_hop    [ROUTE_ENTRIES_DEF];
  logic [7:0]           rt_port   [ROUTE_ENTRIES_DEF];
  bit                   rt_written [ROUTE_ENTRIES_DEF];
  logic [31:0]          arp_ip    [ARP_ENTRIES_DEF];
  logic [47:0]          arp_mac   [ARP_ENTRIES_DEF];
  bit                   arp_written [ARP_ENTRIES_DEF];
  logic [ROUTE_CFG_W-1:0] routes_in_use = '0;
  logic [ARP_CFG_W-1:0]   arps_in_use = '0;

  logic [31:0] net_pool [4];
  logic [31:0] host_pool [8];

  result_t pending_results [$];
  result_t mon_got, mon_want;

  int  send_gap_pct = 0;
  int  rx_stall_pct = 0;
  bit  rx_hold = 1'b0;
  event hold_go;

  int  cycle_cnt = 0;
  int  n_mismatch = 0;
  int  n_lookups = 0;
  int  n_route_hits = 0;
  int  n_arp_hits = 0;
  int  n_tbl_writes = 0;
  int  n_ignored = 0;
  int  n_reg_writes = 0;

  longest_prefix_route_and_arp_lookup_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("longest_prefix_route_and_arp_lookup_top regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always begin
    @(hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got.route_found = m_tdata[0];
      mon_got.arp_found   = m_tdata[1];
      mon_got.out_port    = m_tdata[9:2];
      mon_got.out_gateway = m_tdata[41:10];
      mon_got.out_mac     = m_tdata[89:42];
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("cycle %0d: result with no lookup pending, tdata %h", cycle_cnt, m_tdata);
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got.route_found !== mon_want.route_found ||
            mon_got.arp_found !== mon_want.arp_found ||
            mon_got.out_port !== mon_want.out_port ||
            mon_got.out_gateway !== mon_want.out_gateway ||
            mon_got.out_mac !== mon_want.out_mac) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("cycle %0d: expected found %b/%b port %h hop %h mac %h", cycle_cnt,
                     mon_want.route_found, mon_want.arp_found, mon_want.out_port,
                     mon_want.out_gateway, mon_want.out_mac);
            $display("          actual   found %b/%b port %h hop %h mac %h",
                     mon_got.route_found, mon_got.arp_found, mon_got.out_port,
                     mon_got.out_gateway, mon_got.out_mac);
          end
        end
      end
    end
  end

  // longest prefix match over the shadow tables, then exact ARP search
  function automatic result_t route_lookup(input logic [31:0] dst);
    int      n_rt;
    int      n_arp;
    int      best;
    result_t res;
    n_rt  = (routes_in_use > ROUTE_ENTRIES_DEF) ? ROUTE_ENTRIES_DEF : routes_in_use;
    n_arp = (arps_in_use > ARP_ENTRIES_DEF) ? ARP_ENTRIES_DEF : arps_in_use;
    best  = -1;
    res   = '0;
    for (int i = 0; i < n_rt; i++) begin
      if ((dst & rt_mask[i]) == rt_prefix[i] && (best < 0 || rt_mask[i] > rt_mask[best]))
        best = i;
    end
    if (best >= 0) begin
      res.route_found = 1'b1;
      res.out_port    = rt_port[best];
      res.out_gateway = rt_hop[best];
      for (int i = 0; i < n_arp && !res.arp_found; i++) begin
        if (arp_ip[i] == rt_hop[best]) begin
          res.arp_found = 1'b1;
          res.out_mac   = arp_mac[i];
        end
      end
    end
    return res;
  endfunction

  // number of leading table entries that hold written data
  function automatic int filled_prefix(input bit of_arp);
    int n;
    n = 0;
    if (of_arp)
      while (n < ARP_ENTRIES_DEF && arp_written[n]) n++;
    else
      while (n < ROUTE_ENTRIES_DEF && rt_written[n]) n++;
    return n;
  endfunction

  function automatic req_t rt_wr_row(input logic [9:0] slot, input logic [31:0] prefix,
                                     input logic [31:0] mask, input logic [31:0] hop,
                                     input logic [7:0] port);
    req_t r;
    r = '0;
    r.func = FUNC_ROUTE_WR;
    r.slot = slot;
    r.addr = prefix;
    r.mask = mask;
    r.hop  = hop;
    r.port = port;
    return r;
  endfunction

  function automatic req_t arp_wr_row(input logic [9:0] slot, input logic [31:0] ip,
                                      input logic [47:0] mac);
    req_t r;
    r = '0;
    r.func = FUNC_ARP_WR;
    r.slot = slot;
    r.addr = ip;
    r.mac  = mac;
    return r;
  endfunction

  function automatic req_t lookup_row(input logic [31:0] dst);
    req_t r;
    r = '0;
    r.func = FUNC_LOOKUP;
    r.addr = dst;
    return r;
  endfunction

  function automatic req_t checked_lookup_row(input logic [31:0] dst, input result_t want);
    req_t r;
    r = lookup_row(dst);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic req_t reg_row(input logic idx, input logic [ROUTE_CFG_W-1:0] val);
    req_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // mostly aligned prefixes from a few networks so that routes overlap
  function automatic req_t rand_route_row(input logic [9:0] slot);
    int          len;
    logic [31:0] mask;
    logic [31:0] prefix;
    len    = $urandom_range(1) ? 8 * $urandom_range(0, 4) : $urandom_range(0, 32);
    mask   = ($urandom_range(7) == 0) ? $urandom : (32'hFFFF_FFFF << (32 - len));
    prefix = ($urandom_range(7) == 0) ? $urandom : (net_pool[$urandom_range(3)] & mask);
    return rt_wr_row(slot, prefix, mask,
                     ($urandom_range(3) == 0) ? $urandom : host_pool[$urandom_range(7)],
                     8'($urandom));
  endfunction

  function automatic req_t rand_arp_row(input logic [9:0] slot);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return arp_wr_row(slot, ($urandom_range(7) == 0) ? $urandom : host_pool[$urandom_range(7)],
                      wide[47:0]);
  endfunction

  // destination inside a route in use, now and then anywhere
  function automatic req_t rand_lookup_row();
    int n;
    int j;
    n = (routes_in_use > ROUTE_ENTRIES_DEF) ? ROUTE_ENTRIES_DEF : routes_in_use;
    if (n > 0 && $urandom_range(7) != 0) begin
      j = $urandom_range(0, n - 1);
      return lookup_row((rt_prefix[j] & rt_mask[j]) | ($urandom & ~rt_mask[j]));
    end
    return lookup_row($urandom);
  endfunction

  function automatic req_t random_item();
    int   k;
    int   filled;
    req_t r;
    k      = $urandom_range(99);
    filled = filled_prefix(1'b0);
    if (k < 30) begin
      r = rand_route_row(10'($urandom_range(0, (filled >= 1020) ? 1023 : filled + 3)));
    end else if (k < 45) begin
      r = rand_arp_row(10'(($urandom_range(7) == 0) ? $urandom_range(16, 1023)
                                                     : $urandom_range(0, 15)));
    end else if (k < 95) begin
      r = rand_lookup_row();
    end else begin
      r      = rand_arp_row(10'($urandom_range(0, 1023)));
      r.mask = $urandom;
      r.hop  = $urandom;
      r.port = 8'($urandom);
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input req_t r);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = r.func;
    s_tdata  = {6'd0, r.mac, r.port, r.hop, r.mask, r.addr, r.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (r.func)
      FUNC_ROUTE_WR: begin
        rt_prefix[r.slot]  = r.addr;
        rt_mask[r.slot]    = r.mask;
        rt_hop[r.slot]     = r.hop;
        rt_port[r.slot]    = r.port;
        rt_written[r.slot] = 1'b1;
        n_tbl_writes++;
      end
      FUNC_ARP_WR: begin
        if (r.slot < ARP_ENTRIES_DEF) begin
          arp_ip[r.slot]      = r.addr;
          arp_mac[r.slot]     = r.mac;
          arp_written[r.slot] = 1'b1;
          n_tbl_writes++;
        end else begin
          n_ignored++;
        end
      end
      FUNC_LOOKUP: begin
        if (!r.typed) r.want = route_lookup(r.addr);
        pending_results.push_back(r.want);
        n_lookups++;
        if (r.want.route_found) n_route_hits++;
        if (r.want.arp_found) n_arp_hits++;
      end
      default: n_ignored++;
    endcase
    @(negedge clk);
  endtask

  // only once every lookup has answered and the last write has retired
  task automatic write_reg(input logic idx, input logic [ROUTE_CFG_W-1:0] val);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ROUTE_COUNT)
      routes_in_use = val;
    else
      arps_in_use = val[ARP_CFG_W-1:0];
    n_reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input int n_items, input int gap_pct, input int stall_pct,
                           input int max_routes, input bit hold);
    int rc;
    rc = filled_prefix(1'b0);
    send_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    write_reg(REG_ROUTE_COUNT,
              ROUTE_CFG_W'($urandom_range(0, (rc < max_routes) ? rc : max_routes)));
    write_reg(REG_ARP_COUNT, ROUTE_CFG_W'($urandom_range(0, filled_prefix(1'b1))));
    if (hold) -> hold_go;
    repeat (n_items) push_item(random_item());
  endtask

  initial begin
    req_t directed [$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (net_pool[i]) net_pool[i] = $urandom;
    foreach (host_pool[i]) host_pool[i] = $urandom;

    // empty tables after reset
    directed.push_back(checked_lookup_row(32'hFFFF_FFFF, '0));
    directed.push_back(checked_lookup_row(32'h0000_0000, '0));
    directed.push_back(rt_wr_row(10'd0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 8'd1));
    directed.push_back(rt_wr_row(10'd1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 8'd2));
    directed.push_back(rt_wr_row(10'd2, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 8'd3));
    // same prefix and mask again: the earlier slot must win
    directed.push_back(rt_wr_row(10'd3, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h1111_1111, 8'd4));
    directed.push_back(rt_wr_row(10'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    directed.push_back(rt_wr_row(10'd5, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0A00_0001, 8'd0));
    directed.push_back(rt_wr_row(10'd1023, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 8'd0));
    directed.push_back(arp_wr_row(10'd0, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF));
    directed.push_back(arp_wr_row(10'd1, 32'hC0A8_01FE, 48'h0123_4567_89AB));
    directed.push_back(arp_wr_row(10'd2, 32'hC0A8_01FE, 48'h0000_0000_0001));
    // past the ARP table: dropped, so the /16 next hop stays unresolved
    directed.push_back(arp_wr_row(10'd1023, 32'hC0A8_0001, 48'h0000_0000_0002));
    directed.push_back(reg_row(REG_ROUTE_COUNT, 11'd6));
    directed.push_back(reg_row(REG_ARP_COUNT, 11'd3));
    directed.push_back(lookup_row(32'hC0A8_0105));
    directed.push_back(checked_lookup_row(32'hFFFF_FFFF,
                                          {1'b1, 1'b0, 8'hFF, 32'hFFFF_FFFF, 48'h0}));
    directed.push_back(lookup_row(32'h0A0A_0A0A));
    directed.push_back(lookup_row(32'hC0A8_0042));
    directed.push_back(lookup_row(32'h1234_5678));
    directed.push_back(reg_row(REG_ROUTE_COUNT, 11'd0));
    directed.push_back(checked_lookup_row(32'hC0A8_0105, '0));

    foreach (directed[i]) begin
      if (directed[i].is_reg)
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      else
        push_item(directed[i]);
    end
    push_item(random_item());
    begin
      req_t junk;
      junk      = rand_arp_row(10'd1023);
      junk.func = FUNC_UNUSED;
      push_item(junk);
    end

    for (int s = 0; s < 64; s++) push_item(rand_route_row(10'(s)));
    for (int s = 0; s < ARP_ENTRIES_DEF; s++) push_item(rand_arp_row(10'(s)));

    run_phase(60, 0, 0, 16, 1'b0);
    run_phase(60, 45, 0, 48, 1'b0);
    run_phase(60, 0, 45, 32, 1'b0);
    run_phase(60, 25, 25, 64, 1'b0);
    run_phase(50, 0, 0, 64, 1'b0);
    run_phase(50, 45, 0, 8, 1'b0);
    run_phase(50, 0, 45, 64, 1'b0);
    run_phase(50, 25, 25, 24, 1'b0);
    // receiver holds off while lookups keep coming: output and input back up
    run_phase(40, 0, 0, 16, 1'b1);

    // all leading written routes in use, full ARP table, then a saturated ARP count
    send_gap_pct = 25;
    rx_stall_pct = 25;
    write_reg(REG_ROUTE_COUNT, ROUTE_CFG_W'(filled_prefix(1'b0)));
    write_reg(REG_ARP_COUNT, 11'd16);
    repeat (3) push_item(rand_lookup_row());
    write_reg(REG_ARP_COUNT, 11'd31);
    repeat (3) push_item(rand_lookup_row());
    write_reg(REG_ARP_COUNT, 11'd0);
    repeat (2) push_item(rand_lookup_row());
    write_reg(REG_ROUTE_COUNT, 11'd0);
    push_item(rand_lookup_row());

    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d lookups (%0d routed, %0d resolved by ARP), %0d table writes,",
             n_lookups, n_route_hits, n_arp_hits, n_tbl_writes);
    $display("%0d dropped or unused items, %0d register writes up to saturated counts",
             n_ignored, n_reg_writes);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("longest_prefix_route_and_arp_lookup_top regression: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("longest_prefix_route_and_arp_lookup_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lpra_pkg.sv
rtl/lpra_ram.sv
rtl/lpra_seq.sv
rtl/longest_prefix_route_and_arp_lookup_top.sv
tb/tb.sv
